// ----- hdl/evad_pkg.sv -----
// Shared types, widths and threshold table of the energy voice activity detector.
package evad_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int MAX_FRAME = 1024;
	localparam int CNT_W     = $clog2(MAX_FRAME + 1);
	localparam int SQ_W      = 2 * SAMPLE_W - 1;
	localparam int SUM_W     = SQ_W + $clog2(MAX_FRAME);
	localparam int K_W       = 18;
	localparam int THR_W     = K_W + CNT_W;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 8;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MODE   = 2'd0,
		CFG_SMOOTH = 2'd1,
		CFG_START  = 2'd2,
		CFG_END    = 2'd3
	} cfg_idx_t;

	// Threshold modes
	typedef enum logic [1:0] {
		MODE_QUALITY         = 2'd0,
		MODE_LOW_BITRATE     = 2'd1,
		MODE_AGGRESSIVE      = 2'd2,
		MODE_VERY_AGGRESSIVE = 2'd3
	} mode_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       smooth;
		logic [7:0] start_frames;
		logic [7:0] end_frames;
	} cfg_t;

	// One closed frame handed from the front end to the decision side
	typedef struct packed {
		logic [SUM_W-1:0] energy;
		logic [CNT_W-1:0] count;
		logic             overflow;
	} frame_rec_t;

	// Squared amplitude threshold in Q30 per mode
	function automatic logic [K_W-1:0] k_of_mode(input logic [1:0] m);
		logic [K_W-1:0] k;
		case (mode_t'(m))
			MODE_QUALITY:         k = 18'd241592;
			MODE_LOW_BITRATE:     k = 18'd154619;
			MODE_AGGRESSIVE:      k = 18'd68719;
			MODE_VERY_AGGRESSIVE: k = 18'd26844;
			default:              k = 18'd68719;
		endcase
		return k;
	endfunction

endpackage

// ----- hdl/evad_front.sv -----
// Front end: takes samples, squares them and accumulates frame energy.
module evad_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [evad_pkg::IN_DATA_W-1:0]      s_tdata,
	input  logic                                s_tlast,
	input  logic [evad_pkg::FIFO_CW-1:0]        fifo_count,
	output logic                                push,
	output evad_pkg::frame_rec_t                push_rec
);

	logic                              accept;
	logic                              counted;
	logic [evad_pkg::SAMPLE_W-1:0]     mag;
	logic [2*evad_pkg::SAMPLE_W-1:0]   sq_full;
	logic [evad_pkg::CNT_W-1:0]        count_q;
	logic                              ovf_q;
	logic [evad_pkg::SUM_W-1:0]        energy_q;
	logic [evad_pkg::SUM_W-1:0]        sum_next;

	logic                              valid_s1;
	logic                              last_s1;
	logic                              counted_s1;
	logic                              ovf_s1;
	logic [evad_pkg::SQ_W-1:0]         sq_s1;
	logic [evad_pkg::CNT_W-1:0]        cnt_s1;

	// Room for every frame already in flight plus one more
	assign s_tready = ({1'b0, fifo_count} + {{evad_pkg::FIFO_CW{1'b0}}, (valid_s1 & last_s1)})
		< (evad_pkg::FIFO_CW+1)'(evad_pkg::FIFO_DEPTH);
	assign accept   = s_tvalid & s_tready;
	assign counted  = count_q < evad_pkg::CNT_W'(evad_pkg::MAX_FRAME);

	// Magnitude and square of the incoming sample
	assign mag     = s_tdata[evad_pkg::SAMPLE_W-1] ? (~s_tdata[evad_pkg::SAMPLE_W-1:0] + 1'b1)
		: s_tdata[evad_pkg::SAMPLE_W-1:0];
	assign sq_full = mag * mag;

	// Sample count and overflow flag, tracked at accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			ovf_q    <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				if (s_tlast) begin
					count_q <= '0;
					ovf_q   <= 1'b0;
				end else begin
					count_q <= count_q + evad_pkg::CNT_W'(counted);
					ovf_q   <= ovf_q | ~counted;
				end
			end
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1    <= s_tlast;
			counted_s1 <= counted;
			ovf_s1     <= ovf_q | ~counted;
			sq_s1      <= sq_full[evad_pkg::SQ_W-1:0];
			cnt_s1     <= count_q + evad_pkg::CNT_W'(counted);
		end
	end

	// Energy accumulation; a frame end hands the record to the queue
	assign sum_next = energy_q + (counted_s1 ? evad_pkg::SUM_W'(sq_s1) : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			energy_q <= '0;
		end else if (valid_s1) begin
			energy_q <= last_s1 ? '0 : sum_next;
		end
	end

	assign push              = valid_s1 & last_s1;
	assign push_rec.energy   = sum_next;
	assign push_rec.count    = cnt_s1;
	assign push_rec.overflow = ovf_s1;

endmodule

// ----- hdl/evad_fifo.sv -----
// Short queue of closed frames between the front end and the decision side.
module evad_fifo (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  evad_pkg::frame_rec_t           push_rec,
	input  logic                           pop,
	output evad_pkg::frame_rec_t           pop_rec,
	output logic                           empty,
	output logic [evad_pkg::FIFO_CW-1:0]   count
);

	evad_pkg::frame_rec_t             mem_q [evad_pkg::FIFO_DEPTH];
	logic [evad_pkg::FIFO_AW-1:0]     wr_ptr_q;
	logic [evad_pkg::FIFO_AW-1:0]     rd_ptr_q;
	logic [evad_pkg::FIFO_CW-1:0]     count_q;

	assign empty   = count_q == '0;
	assign count   = count_q;
	assign pop_rec = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + evad_pkg::FIFO_CW'(push) - evad_pkg::FIFO_CW'(pop);
		end
	end

endmodule

// ----- hdl/evad_back.sv -----
// Decision side: threshold compare, run counters, hysteresis and output register.
module evad_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  evad_pkg::cfg_t                      cfg,
	input  logic                                fifo_empty,
	input  evad_pkg::frame_rec_t                fifo_rec,
	output logic                                pop,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [evad_pkg::OUT_DATA_W-1:0]     m_tdata
);

	logic                              en;
	logic                              valid_s1;
	logic [evad_pkg::SUM_W-1:0]        energy_s1;
	logic [evad_pkg::THR_W-1:0]        thr_s1;
	logic                              ovf_s1;

	logic [7:0]                        voice_run_q;
	logic [7:0]                        silence_run_q;
	logic                              state_q;

	logic                              voiced;
	logic [7:0]                        vrun_nxt;
	logic [7:0]                        srun_nxt;
	logic                              state_nxt;

	logic                              out_valid_q;
	logic [3:0]                        out_bits_q;

	assign en  = ~out_valid_q | m_tready;
	assign pop = en & ~fifo_empty;

	// Stage 1: threshold times sample count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= ~fifo_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			energy_s1 <= fifo_rec.energy;
			thr_s1    <= evad_pkg::k_of_mode(cfg.mode) * fifo_rec.count;
			ovf_s1    <= fifo_rec.overflow;
		end
	end

	// Stage 2: decision, runs and hysteresis
	always_comb begin
		voiced    = energy_s1 > evad_pkg::SUM_W'(thr_s1);
		vrun_nxt  = voiced ? ((voice_run_q == 8'hFF) ? voice_run_q : voice_run_q + 8'd1) : 8'd0;
		srun_nxt  = voiced ? 8'd0 : ((silence_run_q == 8'hFF) ? silence_run_q
			: silence_run_q + 8'd1);
		state_nxt = state_q;
		if (cfg.smooth) begin
			if (!state_q && vrun_nxt >= cfg.start_frames) begin
				state_nxt = 1'b1;
			end else if (state_q && srun_nxt >= cfg.end_frames) begin
				state_nxt = 1'b0;
			end
		end else begin
			state_nxt = voiced;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			voice_run_q   <= '0;
			silence_run_q <= '0;
			state_q       <= 1'b0;
			out_valid_q   <= 1'b0;
		end else if (en) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				voice_run_q   <= vrun_nxt;
				silence_run_q <= srun_nxt;
				state_q       <= state_nxt;
			end
		end
	end

	// Output word
	always_ff @(posedge clk) begin
		if (en && valid_s1) begin
			out_bits_q <= {ovf_s1, state_nxt ^ state_q, state_nxt, voiced};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(evad_pkg::OUT_DATA_W-4){1'b0}}, out_bits_q};

endmodule

// ----- hdl/energy_voice_activity_detector_core.sv -----
// Top level of the energy threshold voice activity detector.
// Accepts one signed 16-bit sample per clock on the slave stream while s_tready is high;
// tlast closes a frame and produces one result word on the master stream. A frame is
// voiced when its sum of squares exceeds the mode threshold (Q30) times its sample
// count; frames over 1024 samples are decided on the first 1024 and flagged. Each
// square is registered before accumulation, and a closed frame passes the queue, the
// threshold stage and the output register. Closed frames wait in a
// four-entry queue, so short frames may arrive back to back and the decision side can
// stall on tready without stopping sample intake until that queue fills. Configuration
// writes take effect immediately and must be made while the block is idle.
module energy_voice_activity_detector_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [evad_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [evad_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [evad_pkg::IN_DATA_W-1:0]       s_tdata,   // [15:0] sample
	input  logic                                 s_tlast,   // last_in_frame
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [evad_pkg::OUT_DATA_W-1:0]      m_tdata    // [0] frame_voice, [1] voice_active,
	                                                        // [2] state_changed, [3] frame_overflow
);

	evad_pkg::cfg_t                     cfg_q;
	logic                               push;
	logic                               pop;
	logic                               fifo_empty;
	logic [evad_pkg::FIFO_CW-1:0]       fifo_count;
	evad_pkg::frame_rec_t               push_rec;
	evad_pkg::frame_rec_t               pop_rec;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode         <= evad_pkg::MODE_AGGRESSIVE;
			cfg_q.smooth       <= 1'b1;
			cfg_q.start_frames <= 8'd3;
			cfg_q.end_frames   <= 8'd10;
		end else if (cfg_we) begin
			case (evad_pkg::cfg_idx_t'(cfg_index))
				evad_pkg::CFG_MODE:   cfg_q.mode         <= cfg_data[1:0];
				evad_pkg::CFG_SMOOTH: cfg_q.smooth       <= cfg_data[0];
				evad_pkg::CFG_START:  cfg_q.start_frames <= cfg_data;
				evad_pkg::CFG_END:    cfg_q.end_frames   <= cfg_data;
				default: ;
			endcase
		end
	end

	evad_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.fifo_count (fifo_count),
		.push       (push),
		.push_rec   (push_rec)
	);

	evad_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.pop      (pop),
		.pop_rec  (pop_rec),
		.empty    (fifo_empty),
		.count    (fifo_count)
	);

	evad_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.fifo_empty (fifo_empty),
		.fifo_rec   (pop_rec),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

	// Queue never written while full unless an entry is popped in the same cycle
	a_no_fifo_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && !pop && fifo_count == evad_pkg::FIFO_CW'(evad_pkg::FIFO_DEPTH)))
		else $error("frame queue overrun");

	// Without smoothing the state follows the raw decision
	a_raw_follow: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !cfg_q.smooth) |-> (m_tdata[1] == m_tdata[0]))
		else $error("voice_active differs from frame_voice with smoothing off");

	// A smoothed turn-on needs a voiced frame unless start count is zero
	a_turn_on: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && cfg_q.smooth && m_tdata[2] && m_tdata[1])
		|-> (m_tdata[0] || cfg_q.start_frames == 8'd0))
		else $error("voice turned on by a silent frame");

	// A smoothed turn-off needs a silent frame unless end count is zero
	a_turn_off: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && cfg_q.smooth && m_tdata[2] && !m_tdata[1])
		|-> (!m_tdata[0] || cfg_q.end_frames == 8'd0))
		else $error("voice turned off by a voiced frame");

endmodule

// ----- test/vad_frame_checker.sv -----
// Checker for the voice activity detector: predicts frame decisions and compares results.
`timescale 1ns / 100ps

module vad_frame_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [evad_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [evad_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [evad_pkg::IN_DATA_W-1:0]  s_tdata,   // [15:0] sample
	input  logic                            s_tlast,   // last_in_frame
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [evad_pkg::OUT_DATA_W-1:0] m_tdata,   // [0] frame_voice, [1] voice_active,
	                                                   // [2] state_changed, [3] frame_overflow
	output int                              errors,
	output int                              pending
);

	localparam int N_FIELDS = 4;

	// Result word layout, lowest bit last
	typedef struct packed {
		logic overflow;
		logic changed;
		logic active;
		logic voiced;
	} decision_t;

	// Shadow of the block's frame and run state
	logic [evad_pkg::SUM_W-1:0] energy_acc;
	logic [evad_pkg::CNT_W-1:0] sample_cnt;
	logic                       frame_ovf;
	logic [7:0]                 voiced_run;
	logic [7:0]                 quiet_run;
	logic                       vad_on;
	evad_pkg::cfg_t             cfg;
	decision_t                  expected_decisions [$];
	int                         frame_no;

	// Squared amplitude threshold in Q30
	function automatic logic [evad_pkg::K_W-1:0] q30_threshold(input logic [1:0] m);
		logic [evad_pkg::K_W-1:0] k;
		case (evad_pkg::mode_t'(m))
			evad_pkg::MODE_QUALITY:     k = 18'd241592;
			evad_pkg::MODE_LOW_BITRATE: k = 18'd154619;
			evad_pkg::MODE_AGGRESSIVE:  k = 18'd68719;
			default:                    k = 18'd26844;
		endcase
		return k;
	endfunction

	function automatic string field_label(input int idx);
		case (idx)
			0:       return "frame_voice";
			1:       return "voice_active";
			2:       return "state_changed";
			default: return "frame_overflow";
		endcase
	endfunction

	// Accumulate one sample; a closing sample yields one decision
	task automatic take_sample(input logic [evad_pkg::IN_DATA_W-1:0] smp, input logic lst);
		logic [16:0]                mag;
		logic [evad_pkg::SUM_W-1:0] bound;
		logic                       next_on;
		decision_t                  d;
		mag = smp[15] ? 17'h10000 - {1'b0, smp} : {1'b0, smp};
		if (sample_cnt < evad_pkg::CNT_W'(evad_pkg::MAX_FRAME)) begin
			energy_acc = energy_acc + evad_pkg::SUM_W'(mag) * evad_pkg::SUM_W'(mag);
			sample_cnt = sample_cnt + 1'b1;
		end else begin
			frame_ovf = 1'b1;
		end
		if (lst) begin
			bound = evad_pkg::SUM_W'(q30_threshold(cfg.mode)) * evad_pkg::SUM_W'(sample_cnt);
			d.voiced = energy_acc > bound;
			// run counters saturate at 255
			if (d.voiced) begin
				if (voiced_run != 8'hFF)
					voiced_run = voiced_run + 1'b1;
				quiet_run = '0;
			end else begin
				if (quiet_run != 8'hFF)
					quiet_run = quiet_run + 1'b1;
				voiced_run = '0;
			end
			next_on = vad_on;
			if (cfg.smooth) begin
				if (!vad_on && voiced_run >= cfg.start_frames)
					next_on = 1'b1;
				else if (vad_on && quiet_run >= cfg.end_frames)
					next_on = 1'b0;
			end else begin
				next_on = d.voiced;
			end
			d.changed  = next_on != vad_on;
			vad_on     = next_on;
			d.active   = vad_on;
			d.overflow = frame_ovf;
			expected_decisions.push_back(d);
			energy_acc = '0;
			sample_cnt = '0;
			frame_ovf  = 1'b0;
		end
	endtask

	// Compare one result word against the oldest decision
	task automatic check_result(input logic [evad_pkg::OUT_DATA_W-1:0] word);
		decision_t           d;
		logic [N_FIELDS-1:0] want;
		if (expected_decisions.size() == 0) begin
			errors++;
			$display("%0t: result word expected none got %h", $time, word);
		end else begin
			d    = expected_decisions.pop_front();
			want = d;
			for (int i = 0; i < N_FIELDS; i++) begin
				if (word[i] !== want[i]) begin
					errors++;
					$display("%0t: frame %0d %s expected %0b got %0b",
						$time, frame_no, field_label(i), want[i], word[i]);
				end
			end
			if (word[evad_pkg::OUT_DATA_W-1:N_FIELDS] !== '0) begin
				errors++;
				$display("%0t: frame %0d padding expected 0 got %h",
					$time, frame_no, word[evad_pkg::OUT_DATA_W-1:N_FIELDS]);
			end
			frame_no++;
		end
	endtask

	// Results first, then register writes, then new samples
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			energy_acc = '0;
			sample_cnt = '0;
			frame_ovf  = 1'b0;
			voiced_run = '0;
			quiet_run  = '0;
			vad_on     = 1'b0;
			cfg.mode         = evad_pkg::MODE_AGGRESSIVE;
			cfg.smooth       = 1'b1;
			cfg.start_frames = 8'd3;
			cfg.end_frames   = 8'd10;
			expected_decisions.delete();
			errors   = 0;
			frame_no = 0;
		end else begin
			if (m_tvalid && m_tready)
				check_result(m_tdata);
			if (cfg_we) begin
				case (evad_pkg::cfg_idx_t'(cfg_index))
					evad_pkg::CFG_MODE:   cfg.mode         = cfg_data[1:0];
					evad_pkg::CFG_SMOOTH: cfg.smooth       = cfg_data[0];
					evad_pkg::CFG_START:  cfg.start_frames = cfg_data;
					evad_pkg::CFG_END:    cfg.end_frames   = cfg_data;
					default:              ;
				endcase
			end
			if (s_tvalid && s_tready)
				take_sample(s_tdata, s_tlast);
		end
		pending = expected_decisions.size();
	end

endmodule

// ----- test/tb_top.sv -----
// Testbench top for the voice activity detector: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;

	localparam int HOLD_CYCLES  = 60;
	localparam int DRAIN_CYCLES = 8;
	localparam int TAIL_CYCLES  = 20;

	// Sample loudness classes for random frames
	typedef enum logic [1:0] {
		LVL_RAW,
		LVL_LOUD,
		LVL_EDGE,
		LVL_QUIET
	} level_t;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cfg_we;
	logic [evad_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [evad_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [evad_pkg::IN_DATA_W-1:0]  s_tdata;   // [15:0] sample
	logic                            s_tlast;   // last_in_frame
	logic                            m_tvalid;
	logic                            m_tready;
	logic [evad_pkg::OUT_DATA_W-1:0] m_tdata;   // [0] frame_voice, [1] voice_active,
	                                            // [2] state_changed, [3] frame_overflow
	int                              errors;
	int                              pending;
	bit                              quiet;
	bit                              hold_req;

	energy_voice_activity_detector_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	vad_frame_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.errors    (errors),
		.pending   (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("energy_voice_activity_detector_core regression: fail");
		$finish;
	end

	// Result side: random stall bursts, one long hold on request
	initial begin
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready = 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				m_tready = 1'b0;
				repeat ($urandom_range(0, 7)) @(negedge clk);
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	function automatic logic [evad_pkg::IN_DATA_W-1:0] pick_sample(input level_t lvl);
		int mag;
		case (lvl)
			LVL_RAW:   mag = int'($urandom_range(0, 65535));
			LVL_LOUD:  mag = $urandom_range(600, 32768);
			LVL_EDGE:  mag = $urandom_range(100, 600);
			default:   mag = $urandom_range(0, 40);
		endcase
		if (lvl != LVL_RAW && $urandom_range(0, 1) == 1)
			mag = -mag;
		return evad_pkg::IN_DATA_W'(mag);
	endfunction

	// Offer one sample word, with an optional gap ahead of it
	task automatic send_word(input logic [evad_pkg::IN_DATA_W-1:0] smp, input logic lst);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = smp;
		s_tlast  = lst;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// Random frames with sticky loudness so runs of voiced and silent frames form
	task automatic send_frames(input int n_items);
		level_t lvl;
		int     len;
		int     sent;
		lvl  = LVL_QUIET;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 3) == 0)
				lvl = level_t'($urandom_range(0, 3));
			if ($urandom_range(0, 49) == 0)
				len = $urandom_range(30, 200);
			else
				len = $urandom_range(1, 12);
			for (int i = 0; i < len; i++)
				send_word(pick_sample(lvl), i == len - 1);
			sent += len;
		end
	endtask

	// Wait until every frame result is back and the pipeline has emptied
	task automatic drain();
		s_tvalid = 1'b0;
		s_tlast  = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input evad_pkg::cfg_idx_t idx,
			input logic [evad_pkg::CFG_DATA_W-1:0] val);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	task automatic apply_setting(input evad_pkg::mode_t m, input logic smooth,
			input logic [7:0] start_cnt, input logic [7:0] stop_cnt);
		drain();
		write_reg(evad_pkg::CFG_MODE, evad_pkg::CFG_DATA_W'(m));
		write_reg(evad_pkg::CFG_SMOOTH, evad_pkg::CFG_DATA_W'(smooth));
		write_reg(evad_pkg::CFG_START, start_cnt);
		write_reg(evad_pkg::CFG_END, stop_cnt);
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = evad_pkg::CFG_MODE;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tlast   = 1'b0;
		quiet     = 1'b0;
		hold_req  = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// Reset settings: full scale, threshold edges, turn on after 3, off after 10
		send_word(16'h7FFF, 1'b1);
		send_word(16'h8000, 1'b1);
		send_word(16'd263, 1'b1);
		send_word(16'd262, 1'b1);
		send_word(16'h0000, 1'b1);
		send_word(16'hFEF9, 1'b0);    // -263
		send_word(16'd262, 1'b1);
		send_word(16'h0001, 1'b0);
		send_word(16'hFFFF, 1'b0);
		send_word(16'h0000, 1'b0);
		send_word(16'h0000, 1'b1);
		repeat (8) send_word(16'h0000, 1'b1);
		send_word(16'h0001, 1'b1);
		send_word(16'hFFFF, 1'b1);

		// Zero run counts: state toggles on every frame
		apply_setting(evad_pkg::MODE_QUALITY, 1'b1, 8'd0, 8'd0);
		send_frames(40);

		apply_setting(evad_pkg::MODE_VERY_AGGRESSIVE, 1'b1, 8'd1, 8'd255);
		send_frames(40);

		// Raw flag mode; result side holds off while short frames keep coming
		apply_setting(evad_pkg::MODE_LOW_BITRATE, 1'b0, 8'd3, 8'd10);
		hold_req = 1'b1;
		repeat (30) send_word(pick_sample(LVL_RAW), 1'b1);
		send_frames(40);

		// Voiced run past 255, then a short silent run
		apply_setting(evad_pkg::MODE_AGGRESSIVE, 1'b1, 8'd255, 8'd8);
		repeat (257) send_word(pick_sample(LVL_LOUD), 1'b1);
		repeat (12) send_word(pick_sample(LVL_QUIET), 1'b1);

		repeat (3) begin
			apply_setting(evad_pkg::mode_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
				8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)));
			send_frames(40);
		end

		// Final stretch at full rate on both sides
		quiet = 1'b1;
		apply_setting(evad_pkg::MODE_QUALITY, 1'b1, 8'd2, 8'd4);
		send_frames(60);

		drain();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("energy_voice_activity_detector_core regression: pass");
		else
			$display("energy_voice_activity_detector_core regression: fail");
		$finish;
	end

endmodule
